// ----- rtl/bu2x_pkg.sv -----
// Shared constants, types and helpers for the 2x bilinear upsampler.
// Used by the top level and by its port checker; no dependencies.
package bu2x_pkg;

	// Line buffer depth default (columns of the widest plane)
	localparam int DefMaxWidth = 1024;

	// Field widths
	localparam int PixW   = 8;
	localparam int ChanW  = 16;
	localparam int RowW   = 16;
	localparam int ColW   = 11;
	localparam int HgtW   = 15;
	localparam int WidW   = 11;

	// Stream data widths
	localparam int InTdataW  = 8;
	localparam int PadW      = 5;
	localparam int OutTdataW = ChanW + RowW + ColW + PixW + PadW;

	// Field offsets in the result tdata
	localparam int RowLo = ChanW;
	localparam int ColLo = ChanW + RowW;
	localparam int ValLo = ChanW + RowW + ColW;

	// Configuration port
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_NUM_CHANNELS = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_IN_HEIGHT    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_IN_WIDTH     = 2'd2;

	localparam logic [ChanW-1:0] NumChannelsRst = 16'd1;
	localparam logic [HgtW-1:0]  InHeightRst    = 15'd112;
	localparam logic [WidW-1:0]  InWidthRst     = 11'd88;

	// Output groups one input can complete, in emission order
	localparam logic [1:0] GRP_UPLEFT = 2'd0;  // (r-1, c-1)
	localparam logic [1:0] GRP_UP     = 2'd1;  // (r-1, c), last column
	localparam logic [1:0] GRP_LEFT   = 2'd2;  // (r, c-1), last row
	localparam logic [1:0] GRP_HERE   = 2'd3;  // (r, c), last pixel

	typedef logic signed [PixW-1:0] pix_t;

	// 64/64 blend followed by an arithmetic shift right by 7: floor((a + b) / 2)
	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic signed [PixW:0] s;
		s = {a[PixW-1], a} + {b[PixW-1], b};
		return s[PixW:1];
	endfunction

endpackage

// ----- rtl/bu2x_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data. No dependencies.
module bu2x_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                       rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bilinear_upsample_2x_int8.sv -----
// 2x bilinear upsampler for signed 8-bit planes, one line buffer in RAM.
// Depends on bu2x_pkg and bu2x_ram.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_*     | in        | s_tvalid/s_tready | s_tdata: pixel
//  m_*     | out       | m_tvalid/m_tready | m_tdata: out_channel, out_row, out_col,
//          |           |                   |   out_value; m_tlast: last_of_run
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// Each input completes N results (0, 4, 8 or 16); the single output register issues one result
// per cycle while m_tready does not stall it; one more input can wait in stage 1 meanwhile.
// Each result passes line buffer read (stage 1), emitter (stage 2), then output register.
// Reset clears counters, neighbor registers and valid flags; the line buffer is not cleared.
// Output stalls hold the emitter; the input is taken again once the staged pixel moves on.
module bilinear_upsample_2x_int8
	import bu2x_pkg::*;
#(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InTdataW-1:0]  s_tdata,   // [7:0] pixel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutTdataW-1:0] m_tdata,   // [15:0] out_channel, [31:16] out_row,
	                                        // [42:32] out_col, [50:43] out_value, [55:51] 0
	output logic                 m_tlast,   // last_of_run
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WCW = (CW + 1 > WidW) ? CW + 1 : WidW;
	localparam logic [WCW-1:0] WMax = WCW'(MAX_WIDTH);

	// configuration
	logic [ChanW-1:0] num_ch_q;
	logic [HgtW-1:0]  height_q;
	logic [WidW-1:0]  width_q;

	// position counters
	logic [CW-1:0]    col_q;
	logic [HgtW-1:0]  row_q;
	logic [ChanW-1:0] chan_q;

	// stage 1: line buffer read in flight
	logic             valid_s1;
	pix_t             pix_s1;
	logic [CW-1:0]    col_s1;
	logic [HgtW-1:0]  row_s1;
	logic [ChanW-1:0] chan_s1;
	logic             lastc_s1;
	logic             lastr_s1;
	logic [PixW-1:0]  line_rd;
	pix_t             up_s1;
	logic [3:0]       mask_new;
	logic             adv_s1;

	// stage 2: emitter
	logic [3:0]       mask_s2;
	logic [1:0]       step_s2;
	pix_t             lp_s2;
	pix_t             up_s2;
	pix_t             lc_s2;
	pix_t             cur_s2;
	logic [CW-1:0]    col_s2;
	logic [HgtW-1:0]  row_s2;
	logic [ChanW-1:0] chan_s2;
	pix_t             left_prev_q;
	pix_t             left_cur_q;

	logic [1:0]       grp;
	logic [3:0]       mask_clr;
	logic             last_res;
	logic             fire;
	pix_t             tl, tr, bl, br;
	pix_t             top, bot, val;
	logic [HgtW-1:0]  y_sel;
	logic [CW-1:0]    x_sel;

	// output register
	logic             m_valid_q;
	logic [OutTdataW-1:0] m_data_q;
	logic             m_last_q;

	logic             s_accept;
	logic [WCW-1:0]   w_raw, w_eff;
	logic [HgtW:0]    h_eff;
	logic             last_col, last_row, chan_wrap;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= NumChannelsRst;
			height_q <= InHeightRst;
			width_q  <= InWidthRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_CHANNELS: num_ch_q <= cfg_data;
				CFG_IN_HEIGHT:    height_q <= cfg_data[HgtW-1:0];
				CFG_IN_WIDTH:     width_q  <= cfg_data[WidW-1:0];
				default: ;
			endcase
		end
	end

	// effective bounds: zero counts as one, width saturates at the buffer depth
	always_comb begin
		w_raw = WCW'(width_q);
		if (w_raw == '0) begin
			w_eff = WCW'(1);
		end else if (w_raw > WMax) begin
			w_eff = WMax;
		end else begin
			w_eff = w_raw;
		end
		h_eff     = (height_q == '0) ? (HgtW+1)'(1) : {1'b0, height_q};
		last_col  = (WCW'(col_q) + WCW'(1)) >= w_eff;
		last_row  = ({1'b0, row_q} + (HgtW+1)'(1)) >= h_eff;
		chan_wrap = ({1'b0, chan_q} + (ChanW+1)'(1)) >= {1'b0, num_ch_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
		end else if (s_accept) begin
			if (!last_col) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + HgtW'(1);
				end else begin
					row_q  <= '0;
					chan_q <= chan_wrap ? '0 : chan_q + ChanW'(1);
				end
			end
		end
	end

	// read old row entry and overwrite it with the new pixel in the same cycle
	bu2x_ram #(
		.Width (PixW),
		.Depth (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s_accept),
		.waddr (col_q),
		.wdata (s_tdata[PixW-1:0]),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pix_s1   <= s_tdata[PixW-1:0];
			col_s1   <= col_q;
			row_s1   <= row_q;
			chan_s1  <= chan_q;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
		end
	end

	assign up_s1 = (row_s1 != '0) ? line_rd : '0;
	assign mask_new = {lastr_s1 && lastc_s1,
	                   lastr_s1 && (col_s1 != '0),
	                   (row_s1 != '0) && lastc_s1,
	                   (row_s1 != '0) && (col_s1 != '0)};

	// current group: lowest pending bit
	always_comb begin
		if (mask_s2[0]) begin
			grp = GRP_UPLEFT;
		end else if (mask_s2[1]) begin
			grp = GRP_UP;
		end else if (mask_s2[2]) begin
			grp = GRP_LEFT;
		end else begin
			grp = GRP_HERE;
		end
	end

	assign mask_clr = mask_s2 & ~(4'b0001 << grp);
	assign last_res = (step_s2 == 2'd3) && (mask_clr == '0);
	assign fire     = (mask_s2 != '0) && (!m_valid_q || m_tready);
	assign adv_s1   = valid_s1 && ((mask_s2 == '0) || (fire && last_res));
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2     <= '0;
			step_s2     <= '0;
			left_prev_q <= '0;
			left_cur_q  <= '0;
		end else if (adv_s1) begin
			mask_s2     <= mask_new;
			step_s2     <= '0;
			left_prev_q <= up_s1;
			left_cur_q  <= pix_s1;
		end else if (fire) begin
			step_s2 <= step_s2 + 2'd1;
			if (step_s2 == 2'd3) begin
				mask_s2 <= mask_clr;
			end
		end
	end

	// neighbors are snapshotted before this pixel updates them
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lp_s2   <= left_prev_q;
			up_s2   <= up_s1;
			lc_s2   <= left_cur_q;
			cur_s2  <= pix_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			chan_s2 <= chan_s1;
		end
	end

	always_comb begin
		case (grp)
			GRP_UPLEFT: begin
				tl = lp_s2;  tr = up_s2;  bl = lc_s2;  br = cur_s2;
				y_sel = row_s2 - HgtW'(1);
				x_sel = col_s2 - CW'(1);
			end
			GRP_UP: begin
				tl = up_s2;  tr = up_s2;  bl = cur_s2; br = cur_s2;
				y_sel = row_s2 - HgtW'(1);
				x_sel = col_s2;
			end
			GRP_LEFT: begin
				tl = lc_s2;  tr = cur_s2; bl = lc_s2;  br = cur_s2;
				y_sel = row_s2;
				x_sel = col_s2 - CW'(1);
			end
			default: begin
				tl = cur_s2; tr = cur_s2; bl = cur_s2; br = cur_s2;
				y_sel = row_s2;
				x_sel = col_s2;
			end
		endcase
		top = step_s2[0] ? avg2(tl, tr) : tl;
		bot = step_s2[0] ? avg2(bl, br) : bl;
		val = step_s2[1] ? avg2(top, bot) : top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= {{PadW{1'b0}}, val, ColW'({x_sel, step_s2[0]}),
			             {y_sel, step_s2[1]}, chan_s2};
			m_last_q <= last_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

// ----- rtl/bu2x_chk.sv -----
// Port-level checker for the 2x bilinear upsampler, bound to the top level.
// Depends on bu2x_pkg.
module bu2x_chk
	import bu2x_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OutTdataW-1:0] m_tdata,
	input logic                 m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a run of results leaves without gaps
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a run of results");

	// even column of a group is followed by its odd neighbor on the same row
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tdata[ColLo] |=>
			m_tvalid
			&& (m_tdata[ColLo +: ColW] == $past(m_tdata[ColLo +: ColW]) + ColW'(1))
			&& (m_tdata[RowLo +: RowW] == $past(m_tdata[RowLo +: RowW])))
		else $error("group pair out of order");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OutTdataW-1 -: PadW] == '0)
		else $error("nonzero tdata padding");

endmodule

bind bilinear_upsample_2x_int8 bu2x_chk u_bu2x_chk (.*);

// ----- dv/bu2x_stream_check.sv -----
`timescale 1ns / 1ps
// Stream checker for the 2x bilinear upsampler: tracks geometry writes, predicts every
// upsampled pixel from the accepted input pixels and compares the result stream.
// Depends on bu2x_pkg for field widths, tdata offsets, register and group codes.
module bu2x_stream_check
	import bu2x_pkg::*;
#(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [InTdataW-1:0]  s_tdata,   // [7:0] pixel
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OutTdataW-1:0] m_tdata,   // [15:0] channel, [31:16] row, [42:32] col,
	                                        // [50:43] value
	input  logic                 m_tlast,   // last_of_run
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int FracBits  = 7;
	localparam int WeightOne = 1 << FracBits;
	localparam int WeightHalf = 1 << (FracBits - 1);
	localparam int ReportMax = 10;

	typedef struct packed {
		logic [ChanW-1:0] chan;
		logic [RowW-1:0]  row;
		logic [ColW-1:0]  col;
		pix_t             value;
		logic             last;
	} up_pixel_t;

	up_pixel_t upsampled_q[$];

	// Geometry registers and the block's position in the image
	int num_chan, plane_hgt, plane_wid;
	int col_cnt, row_cnt, chan_cnt;
	int left_cur, left_prev;
	pix_t prev_line [MAX_WIDTH];

	// Weight 128/0 for even offsets, 64/64 for odd ones, then floor shift
	function automatic int weigh_pair(input int a, input int b, input bit odd);
		int w_far;
		w_far = odd ? WeightHalf : 0;
		return ((WeightOne - w_far) * a + w_far * b) >>> FracBits;
	endfunction

	function automatic void push_group(input int y, input int x, input int tl, input int tr,
	                                   input int bl, input int br, input bit closes_run);
		int top, bot, v, out_r, out_c;
		up_pixel_t e;
		for (int dy = 0; dy < 2; dy++) begin
			for (int dx = 0; dx < 2; dx++) begin
				top = weigh_pair(tl, tr, dx[0]);
				bot = weigh_pair(bl, br, dx[0]);
				v = weigh_pair(top, bot, dy[0]);
				out_r = 2 * y + dy;
				out_c = 2 * x + dx;
				e.chan = chan_cnt[ChanW-1:0];
				e.row = out_r[RowW-1:0];
				e.col = out_c[ColW-1:0];
				e.value = v[PixW-1:0];
				e.last = closes_run && dy == 1 && dx == 1;
				upsampled_q.push_back(e);
			end
		end
	endfunction

	function automatic void predict_pixel(input pix_t px);
		int w, h, cur, up;
		bit last_col, last_row;
		logic [3:0] grp_on;
		logic [1:0] last_grp;
		w = (plane_wid == 0) ? 1 : plane_wid;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = (plane_hgt == 0) ? 1 : plane_hgt;
		cur = int'(px);
		last_col = col_cnt + 1 >= w;
		last_row = row_cnt + 1 >= h;
		up = (col_cnt < MAX_WIDTH && row_cnt >= 1) ? int'(prev_line[col_cnt]) : 0;

		grp_on[GRP_UPLEFT] = row_cnt >= 1 && col_cnt >= 1;
		grp_on[GRP_UP]     = row_cnt >= 1 && last_col;
		grp_on[GRP_LEFT]   = last_row && col_cnt >= 1;
		grp_on[GRP_HERE]   = last_row && last_col;
		last_grp = GRP_UPLEFT;
		for (int g = 0; g < 4; g++)
			if (grp_on[g])
				last_grp = 2'(g);

		if (grp_on[GRP_UPLEFT])
			push_group(row_cnt - 1, col_cnt - 1, left_prev, up, left_cur, cur,
			           last_grp == GRP_UPLEFT);
		if (grp_on[GRP_UP])
			push_group(row_cnt - 1, col_cnt, up, up, cur, cur, last_grp == GRP_UP);
		if (grp_on[GRP_LEFT])
			push_group(row_cnt, col_cnt - 1, left_cur, cur, left_cur, cur,
			           last_grp == GRP_LEFT);
		if (grp_on[GRP_HERE])
			push_group(row_cnt, col_cnt, cur, cur, cur, cur, 1'b1);

		if (col_cnt < MAX_WIDTH)
			prev_line[col_cnt] = px;
		left_prev = up;
		left_cur = cur;

		// Counters past a shrunken bound count as the last column or row
		if (!last_col) begin
			col_cnt++;
		end else begin
			col_cnt = 0;
			if (!last_row) begin
				row_cnt++;
			end else begin
				row_cnt = 0;
				chan_cnt = (chan_cnt + 1 >= num_chan) ? 0 : chan_cnt + 1;
			end
		end
	endfunction

	function automatic void check_result();
		up_pixel_t got, want;
		got.chan = m_tdata[ChanW-1:0];
		got.row = m_tdata[RowLo +: RowW];
		got.col = m_tdata[ColLo +: ColW];
		got.value = m_tdata[ValLo +: PixW];
		got.last = m_tlast;
		if (upsampled_q.size() == 0) begin
			mismatches++;
			if (mismatches <= ReportMax)
				$display("unexpected result: ch %0d row %0d col %0d val %0d last %0b",
				         got.chan, got.row, got.col, $signed(got.value), got.last);
		end else begin
			want = upsampled_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= ReportMax) begin
					$display("mismatch: expected ch %0d row %0d col %0d val %0d last %0b",
					         want.chan, want.row, want.col, $signed(want.value), want.last);
					$display("          actual   ch %0d row %0d col %0d val %0d last %0b",
					         got.chan, got.row, got.col, $signed(got.value), got.last);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upsampled_q.delete();
			mismatches = 0;
			num_chan = int'(NumChannelsRst);
			plane_hgt = int'(InHeightRst);
			plane_wid = int'(InWidthRst);
			col_cnt = 0;
			row_cnt = 0;
			chan_cnt = 0;
			left_cur = 0;
			left_prev = 0;
			for (int i = 0; i < MAX_WIDTH; i++)
				prev_line[i] = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NUM_CHANNELS: num_chan = int'(cfg_data);
					CFG_IN_HEIGHT:    plane_hgt = int'(cfg_data[HgtW-1:0]);
					CFG_IN_WIDTH:     plane_wid = int'(cfg_data[WidW-1:0]);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				predict_pixel(s_tdata[PixW-1:0]);
		end
		outstanding = upsampled_q.size();
	end

endmodule

// ----- dv/bilinear_upsample_2x_int8_test.sv -----
`timescale 1ns / 1ps
// Top of the upsampler test: clock, reset, geometry writes, pixel stimulus and verdict.
// Depends on bu2x_pkg, bilinear_upsample_2x_int8 and bu2x_stream_check.
module bilinear_upsample_2x_int8_test
	import bu2x_pkg::*;
();

	localparam int Limit = 400000;
	localparam int HoldCycles = 300;
	localparam int IdlePct = 26;
	localparam int SettleCycles = 8;
	localparam int RandomItems = 75;

	// Edge pixels: a partial row at reset geometry, a plane switch mid-row, 1x1 planes
	localparam pix_t EdgePix [24] = '{
		8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'h40, 8'hC0, 8'h7E,
		8'h80, 8'h7F, 8'h80, 8'h7F, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h01, 8'hFE,
		8'h7F, 8'h80, 8'hFF, 8'h00
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [InTdataW-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OutTdataW-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int holdoffs_asked;
	bit sender_quiet;
	bit receiver_quiet;

	bilinear_upsample_2x_int8 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bu2x_stream_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= Limit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random back-pressure plus requested long hold-offs
	initial begin
		int holdoffs_done;
		holdoffs_done = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoffs_asked > holdoffs_done) begin
				holdoffs_done++;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			m_tready <= receiver_quiet || ($urandom_range(99) >= IdlePct);
		end
	end

	// Leaves s_tvalid high after the transaction; the caller or the next call lowers it
	task automatic send_pixel(input pix_t px);
		if (!sender_quiet)
			while ($urandom_range(99) < IdlePct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int count);
		logic [31:0] rnd;
		for (int i = 0; i < count; i++) begin
			rnd = $urandom;
			send_pixel(rnd[PixW-1:0]);
		end
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [15:0] nch, input logic [15:0] hgt,
	                         input logic [15:0] wid);
		write_reg(CFG_NUM_CHANNELS, nch);
		write_reg(CFG_IN_HEIGHT, hgt);
		write_reg(CFG_IN_WIDTH, wid);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every predicted pixel, then cover inputs with no results
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		int img, nch, hgt, wid, size, count, sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUM_CHANNELS;
		cfg_data = '0;
		holdoffs_asked = 0;
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Partial first row at reset geometry, then shrink the plane mid-row
		for (int i = 0; i < 10; i++)
			send_pixel(EdgePix[i]);
		settle();
		configure(16'd2, 16'd2, 16'd3);
		for (int i = 10; i < 20; i++)
			send_pixel(EdgePix[i]);
		settle();
		// Zero geometry behaves as 1x1 with one channel; high data bits are masked
		configure(16'd0, 16'h8000, 16'hF800);
		for (int i = 20; i < 24; i++)
			send_pixel(EdgePix[i]);
		settle();

		// Maximum geometry and saturated width, then finish on a small plane
		configure(16'hFFFF, 16'h7FFF, 16'h07FF);
		send_random(6);
		settle();
		configure(16'd1, 16'd1, 16'd1024);
		send_random(6);
		settle();
		configure(16'd2, 16'd3, 16'd4);
		send_random(21);
		settle();

		img = 0;
		sent = 0;
		while (sent < RandomItems) begin
			if (img == 0) begin
				nch = 2;
				hgt = 4;
				wid = 5;
				holdoffs_asked++;
			end else begin
				nch = $urandom_range(1, 3);
				hgt = $urandom_range(1, 4);
				wid = ($urandom_range(3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			end
			size = nch * hgt * wid;
			// Cut some images short so the next geometry lands mid-plane
			count = (img != 0 && $urandom_range(3) == 0) ? $urandom_range(1, size) : size;
			if (count > RandomItems - sent)
				count = RandomItems - sent;
			sender_quiet = (img == 2 || img == 3);
			receiver_quiet = (img == 2 || img == 3);
			configure(nch[15:0], hgt[15:0], wid[15:0]);
			send_random(count);
			settle();
			sent += count;
			img++;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
